/* hw/rtl/lpdd_pkg.sv */
// constants shared by the length-prefixed datagram deframer
// no dependencies
package lpdd_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int MAX_FRAME    = 32767;
  localparam int MIN_FRAME    = HEADER_BYTES + 2;

  localparam int CNT_W  = 15;
  localparam int HDR_W  = 8 * HEADER_BYTES;
  localparam int HIDX_W = $clog2(HEADER_BYTES + 1);

  localparam logic [31:0] LOOP_ALT  = 32'h7F00_00FE;
  localparam logic [31:0] LOOP_HOST = 32'h7F00_0001;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_IGNORE_HEADER = 2'd0,
    REG_STRIP_HEADER  = 2'd1,
    REG_BASE_HOST     = 2'd2,
    REG_BASE_PORT     = 2'd3
  } reg_idx_t;

  function automatic logic [31:0] map_loopback(input logic [31:0] host);
    logic [31:0] res;
    res = host;
    if (host == 32'd0 || host == LOOP_ALT) begin
      res = LOOP_HOST;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/length_prefixed_datagram_deframer.sv */
// length-prefixed datagram deframer: one byte in, at most one result out per cycle
// output: a result is registered and appears in the cycle after its byte is accepted
// throughput: one byte per cycle; ready drops only while a result waits downstream
// reset: synchronous, clears config registers, out_valid, stored destination and frame state
// depends on lpdd_pkg
module length_prefixed_datagram_deframer (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic        last,
  output logic [31:0] dest_host,
  output logic [15:0] dest_port,
  output logic [14:0] sent_length
);

  typedef enum logic [1:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  phase_t phase, phase_next;
  logic [7:0]  length_high, length_high_next;
  logic [lpdd_pkg::CNT_W-1:0]  remaining, remaining_next;
  logic [lpdd_pkg::CNT_W-1:0]  emitted_count, emitted_count_next;
  logic [lpdd_pkg::HDR_W-1:0]  header_capture, header_capture_next;
  logic [lpdd_pkg::HIDX_W-1:0] header_index, header_index_next;
  logic [31:0] stored_host, stored_host_next;
  logic [15:0] stored_port, stored_port_next;

  logic        ignore_header, strip_header;
  logic [31:0] base_host;
  logic [15:0] base_port;

  logic        take;
  logic        res_emit;
  logic [7:0]  res_byte;
  lpdd_pkg::kind_t res_kind;
  logic        res_last;
  logic [15:0] len16;
  logic [lpdd_pkg::CNT_W-1:0] rem_dec;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[3:2];
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign len16    = {length_high, data_byte};
  assign rem_dec  = remaining - lpdd_pkg::CNT_W'(1);

  always_comb begin
    case (cfg_idx)
      lpdd_pkg::REG_IGNORE_HEADER: prdata = {31'd0, ignore_header};
      lpdd_pkg::REG_STRIP_HEADER:  prdata = {31'd0, strip_header};
      lpdd_pkg::REG_BASE_HOST:     prdata = base_host;
      lpdd_pkg::REG_BASE_PORT:     prdata = {16'd0, base_port};
      default:                     prdata = 32'd0;
    endcase
  end

  always_comb begin
    phase_next          = phase;
    length_high_next    = length_high;
    remaining_next      = remaining;
    emitted_count_next  = emitted_count;
    header_capture_next = header_capture;
    header_index_next   = header_index;
    stored_host_next    = stored_host;
    stored_port_next    = stored_port;
    res_emit = 1'b0;
    res_byte = 8'd0;
    res_kind = lpdd_pkg::KIND_DATA;
    res_last = 1'b0;

    case (phase)
      PH_LEN_HI: begin
        length_high_next = data_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (len16 < 16'(lpdd_pkg::MIN_FRAME) || len16 > 16'(lpdd_pkg::MAX_FRAME)) begin
          phase_next = PH_LEN_HI;
          res_emit   = 1'b1;
          res_kind   = lpdd_pkg::KIND_BAD;
        end else begin
          remaining_next      = len16[lpdd_pkg::CNT_W-1:0] - lpdd_pkg::CNT_W'(2);
          emitted_count_next  = '0;
          header_capture_next = '0;
          header_index_next   = '0;
          phase_next          = PH_HEADER;
        end
      end
      PH_HEADER: begin
        header_capture_next = {header_capture[lpdd_pkg::HDR_W-9:0], data_byte};
        header_index_next   = header_index + lpdd_pkg::HIDX_W'(1);
        remaining_next      = rem_dec;
        if (!strip_header) begin
          emitted_count_next = emitted_count + lpdd_pkg::CNT_W'(1);
        end
        res_byte = data_byte;
        if (header_index_next < lpdd_pkg::HIDX_W'(lpdd_pkg::HEADER_BYTES)) begin
          res_emit = !strip_header;
        end else begin
          // full header in hand: host in the upper four bytes, port in the lower two
          if (!ignore_header && header_capture_next != '0) begin
            stored_host_next = header_capture_next[47:16];
            stored_port_next = header_capture_next[15:0];
          end
          if (rem_dec != '0) begin
            phase_next = PH_PAYLOAD;
            res_emit   = !strip_header;
          end else begin
            phase_next = PH_LEN_HI;
            res_emit   = 1'b1;
            res_last   = 1'b1;
            if (strip_header) begin
              res_kind = lpdd_pkg::KIND_END;
              res_byte = 8'd0;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        remaining_next     = rem_dec;
        emitted_count_next = emitted_count + lpdd_pkg::CNT_W'(1);
        res_emit           = 1'b1;
        res_byte           = data_byte;
        if (rem_dec == '0) begin
          phase_next = PH_LEN_HI;
          res_last   = 1'b1;
        end
      end
      default: begin
        phase_next = PH_LEN_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN_HI;
      length_high    <= '0;
      remaining      <= '0;
      emitted_count  <= '0;
      header_capture <= '0;
      header_index   <= '0;
      stored_host    <= '0;
      stored_port    <= '0;
      ignore_header  <= 1'b0;
      strip_header   <= 1'b0;
      base_host      <= '0;
      base_port      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        phase          <= phase_next;
        length_high    <= length_high_next;
        remaining      <= remaining_next;
        emitted_count  <= emitted_count_next;
        header_capture <= header_capture_next;
        header_index   <= header_index_next;
      end
      // writes to the base host and base port registers also reload the stored destination
      if (cfg_wr && cfg_idx == lpdd_pkg::REG_BASE_HOST) begin
        stored_host <= pwdata;
      end else if (take) begin
        stored_host <= stored_host_next;
      end
      if (cfg_wr && cfg_idx == lpdd_pkg::REG_BASE_PORT) begin
        stored_port <= pwdata[15:0];
      end else if (take) begin
        stored_port <= stored_port_next;
      end
      if (in_ready) begin
        out_valid <= take && res_emit;
      end
      if (cfg_wr) begin
        case (cfg_idx)
          lpdd_pkg::REG_IGNORE_HEADER: ignore_header <= pwdata[0];
          lpdd_pkg::REG_STRIP_HEADER:  strip_header  <= pwdata[0];
          lpdd_pkg::REG_BASE_HOST:     base_host     <= pwdata;
          lpdd_pkg::REG_BASE_PORT:     base_port     <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // result register, loaded whenever a byte produces a result
  always_ff @(posedge clk) begin
    if (take && res_emit) begin
      out_byte <= res_byte;
      kind     <= res_kind;
      last     <= res_last;
      if (res_last) begin
        dest_host   <= lpdd_pkg::map_loopback(stored_host_next);
        dest_port   <= stored_port_next;
        sent_length <= (res_kind == lpdd_pkg::KIND_DATA) ? emitted_count_next : '0;
      end else begin
        dest_host   <= '0;
        dest_port   <= '0;
        sent_length <= '0;
      end
    end
  end

endmodule
